FILE: hdl/assert_macros.svh
// Assertion helpers for the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Implication whose consequence is checked the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: hdl/rhct_pkg.sv
`timescale 1ns / 1ps

package rhct_pkg;

    // Width of the CORDIC datapath (Q2.30 values with gain headroom).
    localparam int CW = 36;
    localparam int ATAN_LEN = 24;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int OUT_FRAC_BITS_DEF = 16;

    localparam logic signed [17:0] FULL_TURN    = 18'sd92160;
    localparam logic signed [17:0] HALF_TURN    = 18'sd46080;
    localparam logic signed [17:0] QUARTER_TURN = 18'sd23040;
    localparam logic signed [26:0] DEG_TO_RAD_Q8 = 27'sd18740330;
    localparam logic signed [CW-1:0] CORDIC_X0 = 36'sd652032874;

    // Configuration register indexes.
    localparam logic [2:0] REG_CELL_WIDTH  = 3'd0;
    localparam logic [2:0] REG_CELL_HEIGHT = 3'd1;
    localparam logic [2:0] REG_THICKNESS   = 3'd2;
    localparam logic [2:0] REG_HOLE_WIDTH  = 3'd3;
    localparam logic [2:0] REG_HOLE_HEIGHT = 3'd4;

    function automatic logic signed [CW-1:0] atan_q30(input int i);
        logic signed [CW-1:0] v;
        v = '0;
        unique case (i)
            0:  v = 36'sd843314857;
            1:  v = 36'sd497837829;
            2:  v = 36'sd263043837;
            3:  v = 36'sd133525159;
            4:  v = 36'sd67021687;
            5:  v = 36'sd33543516;
            6:  v = 36'sd16775851;
            7:  v = 36'sd8388437;
            8:  v = 36'sd4194283;
            9:  v = 36'sd2097149;
            10: v = 36'sd1048576;
            11: v = 36'sd524288;
            12: v = 36'sd262144;
            13: v = 36'sd131072;
            14: v = 36'sd65536;
            15: v = 36'sd32768;
            16: v = 36'sd16384;
            17: v = 36'sd8192;
            18: v = 36'sd4096;
            19: v = 36'sd2048;
            20: v = 36'sd1024;
            21: v = 36'sd512;
            22: v = 36'sd256;
            23: v = 36'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/rhct_cordic.sv
`timescale 1ns / 1ps

// Pipelined sine and cosine of an angle in 1/256 degree.
// Folded angle, seed, each rotation and sign fix register on en.
module rhct_cordic import rhct_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [16:0]   angle,
    output logic signed [CW-1:0] sin_val,
    output logic signed [CW-1:0] cos_val
);

    logic signed [17:0] r0, r1, r2;
    logic               flip_next;
    logic signed [15:0] r_reg;
    logic               flip_a_reg;
    logic signed [42:0] zprod;
    logic signed [CW-1:0] z0_next;

    logic signed [CW-1:0] x_reg [0:CORDIC_STAGES];
    logic signed [CW-1:0] y_reg [0:CORDIC_STAGES];
    logic signed [CW-1:0] z_reg [0:CORDIC_STAGES];
    logic                 f_reg [0:CORDIC_STAGES];
    logic signed [CW-1:0] sin_reg, cos_reg;

    // Reduce into (-180,180], then fold into [-90,90] with a sign flip.
    always_comb
    begin
        r0 = {angle[16], angle};
        r1 = (r0 < 0) ? r0 + FULL_TURN : r0;
        if (r1 > HALF_TURN)
        begin
            r1 = r1 - FULL_TURN;
        end
        flip_next = 1'b0;
        r2 = r1;
        if (r1 > QUARTER_TURN)
        begin
            r2 = r1 - HALF_TURN;
            flip_next = 1'b1;
        end
        else if (r1 < -QUARTER_TURN)
        begin
            r2 = r1 + HALF_TURN;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg      <= r2[15:0];
            flip_a_reg <= flip_next;
        end
    end

    assign zprod   = 43'(r_reg) * 43'(DEG_TO_RAD_Q8) + 43'sd128;
    assign z0_next = CW'(zprod >>> 8);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= CORDIC_X0;
            y_reg[0] <= '0;
            z_reg[0] <= z0_next;
            f_reg[0] <= flip_a_reg;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (i >= ATAN_LEN)
                begin
                    x_reg[i+1] <= x_reg[i];
                    y_reg[i+1] <= y_reg[i];
                    z_reg[i+1] <= z_reg[i];
                end
                else if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end
                f_reg[i+1] <= f_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= f_reg[CORDIC_STAGES] ? -y_reg[CORDIC_STAGES] : y_reg[CORDIC_STAGES];
            cos_reg <= f_reg[CORDIC_STAGES] ? -x_reg[CORDIC_STAGES] : x_reg[CORDIC_STAGES];
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

    // The residual angle is not an output.
    logic unused_z;
    assign unused_z = ^z_reg[CORDIC_STAGES];

endmodule

FILE: hdl/rhct_factor.sv
`timescale 1ns / 1ps

// One transmission factor, (hole*x - thick*y) / (pitch*x), saturated to 1.0.
// Zero when x or the numerator is not positive; one quotient bit per stage.
module rhct_factor import rhct_pkg::*; #(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [15:0]              hole,
    input  logic [15:0]              thick,
    input  logic [15:0]              pitch,
    input  logic signed [CW-1:0]     x,
    input  logic signed [CW-1:0]     ymag,
    output logic [OUT_FRAC_BITS:0]   factor
);

    localparam int NW = CW + 18;
    localparam logic [OUT_FRAC_BITS:0] ONE = (OUT_FRAC_BITS+1)'(1) << OUT_FRAC_BITS;

    logic signed [NW-1:0] hx_reg, ty_reg, px_reg;
    logic                 xpos_reg;
    logic signed [NW-1:0] num;

    logic [NW-1:0]            r_reg [0:OUT_FRAC_BITS];
    logic [NW-1:0]            d_reg [0:OUT_FRAC_BITS];
    logic [OUT_FRAC_BITS-1:0] q_reg [0:OUT_FRAC_BITS];
    logic                     zero_reg [0:OUT_FRAC_BITS];
    logic                     one_reg [0:OUT_FRAC_BITS];
    logic [OUT_FRAC_BITS:0]   f_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hx_reg   <= NW'($signed({1'b0, hole})) * NW'(x);
            ty_reg   <= NW'($signed({1'b0, thick})) * NW'(ymag);
            px_reg   <= NW'($signed({1'b0, pitch})) * NW'(x);
            xpos_reg <= (x > 0);
        end
    end

    assign num = hx_reg - ty_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]    <= num;
            d_reg[0]    <= px_reg;
            q_reg[0]    <= '0;
            zero_reg[0] <= !xpos_reg || (num <= 0);
            one_reg[0]  <= (num >= px_reg);
        end
    end

    for (genvar k = 0; k < OUT_FRAC_BITS; k++)
    begin : g_div
        logic [NW-1:0] rs;
        assign rs = r_reg[k] << 1;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rs >= d_reg[k])
                begin
                    r_reg[k+1] <= rs - d_reg[k];
                    q_reg[k+1] <= {q_reg[k][OUT_FRAC_BITS-2:0], 1'b1};
                end
                else
                begin
                    r_reg[k+1] <= rs;
                    q_reg[k+1] <= {q_reg[k][OUT_FRAC_BITS-2:0], 1'b0};
                end
                d_reg[k+1]    <= d_reg[k];
                zero_reg[k+1] <= zero_reg[k];
                one_reg[k+1]  <= one_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_reg[OUT_FRAC_BITS])
            begin
                f_reg <= '0;
            end
            else if (one_reg[OUT_FRAC_BITS])
            begin
                f_reg <= ONE;
            end
            else
            begin
                f_reg <= {1'b0, q_reg[OUT_FRAC_BITS]};
            end
        end
    end

    assign factor = f_reg;

    logic unused_rem;
    assign unused_rem = ^{r_reg[OUT_FRAC_BITS], d_reg[OUT_FRAC_BITS]};

endmodule

FILE: hdl/rect_hole_cell_transmittance.sv
`timescale 1ns / 1ps
// Channel   Handshake                 Word
// input     in_valid / in_ready       zenith_angle, azimuth_angle, profile_angle
// output    out_valid / out_ready     transmittance
// config    cfg_we (no wait)          cfg_index, cfg_data
//
// A word can enter every cycle while in_ready is high; its result passes through
// the CORDIC stages, the one-bit-per-stage divider and the output product.
// Reset clears the stage valid bits and loads the register reset values.
// When the output word is not taken, the whole pipeline holds and in_ready drops;
// no word is lost or repeated.

`include "assert_macros.svh"

module rect_hole_cell_transmittance import rhct_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [14:0]            zenith_angle,
    input  logic signed [16:0]     azimuth_angle,
    input  logic signed [15:0]     profile_angle,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_FRAC_BITS:0] transmittance,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [15:0]            cfg_data
);

    // Total number of register stages from input to output.
    localparam int LAT = CORDIC_STAGES + OUT_FRAC_BITS + 10;
    localparam logic [OUT_FRAC_BITS:0] ONE = (OUT_FRAC_BITS+1)'(1) << OUT_FRAC_BITS;
    localparam int PW = 2 * (OUT_FRAC_BITS + 1);

    logic [15:0] cell_width_reg, cell_height_reg, thickness_reg;
    logic [15:0] hole_width_reg, hole_height_reg;

    logic           adv;
    logic [LAT-1:0] vld_reg;

    // The user sends configuration writes only while the pipeline is empty; unchecked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_width_reg  <= 16'd1000;
            cell_height_reg <= 16'd1000;
            thickness_reg   <= 16'd100;
            hole_width_reg  <= 16'd500;
            hole_height_reg <= 16'd500;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CELL_WIDTH:  cell_width_reg  <= cfg_data;
                REG_CELL_HEIGHT: cell_height_reg <= cfg_data;
                REG_THICKNESS:   thickness_reg   <= cfg_data;
                REG_HOLE_WIDTH:  hole_width_reg  <= cfg_data;
                REG_HOLE_HEIGHT: hole_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline moves as one unit whenever the output stage can drain.
    assign adv       = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // Three sine/cosine pipelines run side by side.
    logic signed [CW-1:0] st, ct, sp, cp, ss, cs;

    rhct_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_theta (
        .clk(clk), .en(adv), .angle($signed({2'b00, zenith_angle})),
        .sin_val(st), .cos_val(ct)
    );
    rhct_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_phi (
        .clk(clk), .en(adv), .angle(azimuth_angle),
        .sin_val(sp), .cos_val(cp)
    );
    rhct_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_psi (
        .clk(clk), .en(adv), .angle({profile_angle[15], profile_angle}),
        .sin_val(ss), .cos_val(cs)
    );

    // cos(phi)*sin(theta) >> 30, split into two partial products so that no
    // single multiplier exceeds the width of the datapath by much.
    logic signed [CW-18:0]   st_hi;
    logic signed [17:0]      st_lo;
    logic signed [CW+18:0]   ph_reg, pl_reg;
    logic signed [CW-1:0]    ct_d1_reg, cs_d1_reg, ss_d1_reg;
    logic signed [2*CW-1:0]  ye_full;
    logic signed [CW-1:0]    ye_s;
    logic signed [CW-1:0]    ye_reg, ct_d2_reg, cs_d2_reg, ssm_reg;

    assign st_hi = st[CW-1:17];
    assign st_lo = $signed({1'b0, st[16:0]});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ph_reg    <= (CW+19)'(cp) * (CW+19)'(st_hi);
            pl_reg    <= (CW+19)'(cp) * (CW+19)'(st_lo);
            ct_d1_reg <= ct;
            cs_d1_reg <= cs;
            ss_d1_reg <= ss;
        end
    end

    assign ye_full = ((2*CW)'(ph_reg) <<< 17) + (2*CW)'(pl_reg);
    assign ye_s    = CW'(ye_full >>> 30);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ye_reg    <= (ye_s < 0) ? -ye_s : ye_s;
            ssm_reg   <= (ss_d1_reg < 0) ? -ss_d1_reg : ss_d1_reg;
            ct_d2_reg <= ct_d1_reg;
            cs_d2_reg <= cs_d1_reg;
        end
    end

    logic [OUT_FRAC_BITS:0] fh, fv;

    rhct_factor #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_fh (
        .clk(clk), .en(adv), .hole(hole_width_reg), .thick(thickness_reg),
        .pitch(cell_width_reg), .x(ct_d2_reg), .ymag(ye_reg), .factor(fh)
    );
    rhct_factor #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_fv (
        .clk(clk), .en(adv), .hole(hole_height_reg), .thick(thickness_reg),
        .pitch(cell_height_reg), .x(cs_d2_reg), .ymag(ssm_reg), .factor(fv)
    );

    // Product of the two factors, then shift and saturate into the output word.
    logic [PW-1:0]          prod_reg;
    logic [PW-1:0]          prod_sh;
    logic [OUT_FRAC_BITS:0] out_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= PW'(fh) * PW'(fv);
        end
    end

    assign prod_sh = prod_reg >> OUT_FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= (prod_sh > PW'(ONE)) ? ONE : prod_sh[OUT_FRAC_BITS:0];
        end
    end

    assign transmittance = out_reg;

    // The azimuth sine is not needed.
    logic unused_sp;
    assign unused_sp = ^sp;

    `ASSERT_IMPL(a_out_sat, clk, rst_n, out_valid, transmittance <= ONE, "transmittance above 1.0")
    `ASSERT_IMPL(a_ready, clk, rst_n, 1'b1, in_ready == (!out_valid || out_ready), "ready mismatch")
    `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, $stable(vld_reg), "pipeline moved")

endmodule

FILE: tb/rect_hole_cell_transmittance_checker.sv
`timescale 1ns / 1ps

module rect_hole_cell_transmittance_checker import rhct_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [14:0] zenith_angle,
    input  logic signed [16:0] azimuth_angle,
    input  logic signed [15:0] profile_angle,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [16:0] transmittance,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    localparam int STAGES = 16;
    localparam int FRAC = 16;

    logic [15:0] pitch_h, pitch_v, thick, hole_h, hole_v;
    logic [16:0] expected_tx[$];

    assign pending = expected_tx.size();

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    // Fixed-point CORDIC sine and cosine of an angle in 1/256 degree.
    function automatic void sincos(input longint ang, output longint s, output longint c);
        longint r, x, y, z, nx;
        bit flip;
        r = ang % 92160;
        flip = 0;
        if (r < 0) r += 92160;
        if (r > 46080) r -= 92160;
        if (r > 23040)
        begin
            r -= 46080;
            flip = 1;
        end
        else if (r < -23040)
        begin
            r += 46080;
            flip = 1;
        end
        z = fshr(r * 18740330 + 128, 8);
        x = 652032874;
        y = 0;
        for (int i = 0; i < STAGES && i < ATAN_LEN; i++)
        begin
            if (z >= 0)
            begin
                nx = x - fshr(y, i);
                y = y + fshr(x, i);
                z -= longint'(atan_q30(i));
            end
            else
            begin
                nx = x + fshr(y, i);
                y = y - fshr(x, i);
                z += longint'(atan_q30(i));
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    // One open-area factor in Q1.16, with restoring division.
    function automatic longint open_factor(longint hole, longint th, longint pitch,
                                           longint x, longint ymag);
        longint num, den, q, r;
        if (x <= 0) return 0;
        num = hole * x - th * ymag;
        if (num <= 0) return 0;
        den = pitch * x;
        if (num >= den) return longint'(1) << FRAC;
        q = 0;
        r = num;
        for (int k = 0; k < FRAC; k++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r -= den;
                q |= 1;
            end
        end
        return q;
    endfunction

    function automatic logic [16:0] predict_tx(longint th_a, longint ph_a, longint ps_a);
        longint st, ct, sp, cp, ss, cs, ye, fh, fv, t;
        sincos(th_a, st, ct);
        sincos(ph_a, sp, cp);
        sincos(ps_a, ss, cs);
        ye = fshr(cp * st, 30);
        if (ye < 0) ye = -ye;
        if (ss < 0) ss = -ss;
        fh = open_factor(hole_h, thick, pitch_h, ct, ye);
        fv = open_factor(hole_v, thick, pitch_v, cs, ss);
        t = (fh * fv) >> FRAC;
        if (t > 65536) t = 65536;
        return t[16:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_h <= 16'd1000;
            pitch_v <= 16'd1000;
            thick <= 16'd100;
            hole_h <= 16'd500;
            hole_v <= 16'd500;
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CELL_WIDTH:  pitch_h <= cfg_data;
                    REG_CELL_HEIGHT: pitch_v <= cfg_data;
                    REG_THICKNESS:   thick <= cfg_data;
                    REG_HOLE_WIDTH:  hole_h <= cfg_data;
                    REG_HOLE_HEIGHT: hole_v <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_tx.push_back(predict_tx(zenith_angle, azimuth_angle,
                                                 profile_angle));
            if (out_valid && out_ready)
            begin
                if (expected_tx.size() == 0)
                    report_mismatch("word with nothing expected");
                else if (transmittance !== expected_tx[0])
                begin
                    report_mismatch($sformatf("transmittance %0d, expected %0d",
                                              transmittance, expected_tx[0]));
                    void'(expected_tx.pop_front());
                end
                else
                    void'(expected_tx.pop_front());
            end
        end
    end

endmodule

FILE: tb/rect_hole_cell_transmittance_tb.sv
`timescale 1ns / 1ps

module rect_hole_cell_transmittance_tb;
    import rhct_pkg::*;

    // Pipeline depth, equal to LAT in the block.
    localparam int LATENCY = CORDIC_STAGES_DEF + OUT_FRAC_BITS_DEF + 10;
    localparam int WATCHDOG = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [14:0] zenith_angle = '0;
    logic signed [16:0] azimuth_angle = '0;
    logic signed [15:0] profile_angle = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [16:0] transmittance;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_off = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    rect_hole_cell_transmittance dut (.*);

    rect_hole_cell_transmittance_checker checker_i (.*);

    // The receiver stalls at random, or holds off completely for a counted
    // stretch while the sender keeps pushing, so the pipeline fills up.
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            out_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else if (hold_req && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_off <= 300;
            hold_done <= 1'b1;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: count cycles in which no word moves on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one word and hold it until in_ready is seen high after an edge.
    // A random gap of idle cycles may come first, per the current idling phase.
    task automatic send_word(input logic [14:0] zen, input logic signed [16:0] azi,
                             input logic signed [15:0] prof);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        zenith_angle <= zen;
        azimuth_angle <= azi;
        profile_angle <= prof;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stop sending and let every expected word arrive, then let the pipeline
    // settle so that configuration writes land on an idle block.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // Drive one register write; the caller drops the write enable afterwards.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic set_geometry(input logic [15:0] pw, input logic [15:0] ph,
                                input logic [15:0] th, input logic [15:0] hw,
                                input logic [15:0] hh);
        write_reg(REG_CELL_WIDTH, pw);
        write_reg(REG_CELL_HEIGHT, ph);
        write_reg(REG_THICKNESS, th);
        write_reg(REG_HOLE_WIDTH, hw);
        write_reg(REG_HOLE_HEIGHT, hh);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly in-range angles, sometimes raw bit patterns that need reduction
    // modulo a full turn.
    task automatic random_word;
        logic [14:0] zen;
        logic signed [16:0] azi;
        logic signed [15:0] prof;
        if ($urandom_range(9) == 0)
        begin
            zen = 15'($urandom);
            azi = 17'($urandom);
            prof = 16'($urandom);
        end
        else
        begin
            zen = 15'($urandom_range(23040));
            azi = 17'(int'($urandom_range(92160)) - 46080);
            prof = 16'(int'($urandom_range(46080)) - 23040);
        end
        send_word(zen, azi, prof);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset geometry: extremes, normal incidence,
        // the cutoff region and out-of-range angles.
        send_word(15'd0, 17'sd0, 16'sd0);
        send_word(15'd23040, 17'sd0, 16'sd0);
        send_word(15'd0, 17'sd0, 16'sd23040);
        send_word(15'd0, 17'sd0, -16'sd23040);
        send_word(15'd11520, 17'sd46080, 16'sd0);
        send_word(15'd11520, -17'sd46080, 16'sd0);
        send_word(15'd11520, 17'sd23040, 16'sd2000);
        send_word(15'd1000, 17'sd0, 16'sd1000);
        send_word(15'h7FFF, 17'sh0FFFF, 16'sh7FFF);
        send_word(15'h7FFF, -17'sd65536, -16'sd32768);
        send_word(15'd22000, 17'sd12345, -16'sd22000);
        drain();

        // Hole at or above pitch saturates the factor; zero thickness gives
        // hole over pitch alone.
        set_geometry(16'd100, 16'd100, 16'd0, 16'd200, 16'd100);
        send_word(15'd5000, 17'sd3000, 16'sd4000);
        send_word(15'd0, 17'sd0, 16'sd0);
        send_word(15'd23040, 17'sd0, 16'sd23040);
        drain();

        // Extremes of every register, and a zero hole.
        set_geometry(16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'd0);
        send_word(15'd256, 17'sd512, 16'sd256);
        send_word(15'd0, 17'sd0, 16'sd0);
        drain();
        set_geometry(16'd1, 16'hFFFF, 16'd1, 16'd1, 16'hFFFF);
        send_word(15'd256, 17'sd512, 16'sd256);
        send_word(15'd12000, -17'sd30000, 16'sd100);
        drain();

        // Random phases: each geometry sees one idling pattern.
        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 77;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 77;
                end
                default:
                begin
                    send_idle_pct = 15;
                    stall_pct = 15;
                end
            endcase
            if (phase == 0)
                set_geometry(16'd1000, 16'd1000, 16'd100, 16'd500, 16'd500);
            else
                set_geometry(16'($urandom_range(2000, 1)), 16'($urandom_range(2000, 1)),
                             16'($urandom_range(1500)), 16'($urandom_range(2000)),
                             16'($urandom_range(2000)));
            for (int n = 0; n < 155; n++)
            begin
                // Long receiver hold-off while the sender keeps offering.
                if (phase == 1 && n == 10)
                    hold_req <= 1'b1;
                random_word();
            end
            // The sender pauses here until every expected word has come.
            drain();
        end

        send_idle_pct = 0;
        stall_pct = 0;
        drain();

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/rhct_pkg.sv
hdl/rhct_cordic.sv
hdl/rhct_factor.sv
hdl/rect_hole_cell_transmittance.sv
tb/rect_hole_cell_transmittance_checker.sv
tb/rect_hole_cell_transmittance_tb.sv
